[hw/rtl/kvt_pkg.sv]
// kvt_pkg: shared types, codes and constants of the key/value table
// depends on nothing; used by kvt_cell and key_value_table_top
package kvt_pkg;

	// default number of table slots
	localparam int KVT_CAPACITY = 16;

	// operation codes
	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_LOOKUP = 2'd1;
	localparam logic [1:0] KIND_ERASE  = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	// result status codes
	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	// value reported on a lookup miss
	localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

	// request item
	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] req_key;
		logic signed [31:0] req_value;
	} kvt_in_t;

	// result item
	typedef struct packed {
		logic signed [31:0] found_value;
		logic               hit;
		logic [1:0]         status;
		logic [4:0]         entry_count;
	} kvt_out_t;

	// request held for the whole scan, seen by every cell
	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] req_key;
		logic signed [31:0] req_value;
		logic               fill;
	} kvt_req_t;

	// token handed from cell to cell
	typedef struct packed {
		logic               act;
		logic               hit;
		logic               taken;
		logic signed [31:0] found;
	} kvt_carry_t;

endpackage

[hw/rtl/kvt_stream_if.sv]
// kvt_stream_if: valid/ready channel carrying one item of a given payload type
// depends on nothing; payload types come from kvt_pkg at the point of use
interface kvt_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/key_value_table_top.sv]
// key_value_table_top: bounded key/value table built as a chain of slot cells
// depends on kvt_pkg, kvt_stream_if and kvt_cell
//
//  channel | dir | payload                                    | accepted when
//  req     | in  | kind, req_key, req_value                   | req.valid && req.ready
//  rsp     | out | found_value, hit, status, entry_count      | rsp.valid && rsp.ready
//
// a search token walks the cells, one cell per cycle; an item makes a search pass,
// and an insert of a new key makes a search pass then a fill pass
// one item at a time: req.ready is high only between items
// the result sits in an output register, so the next item is taken while it waits
// reset clears all valid bits and the entry count at once; no clearing pass
module key_value_table_top #(
	parameter int CAPACITY = kvt_pkg::KVT_CAPACITY
) (
	input logic          clk,
	input logic          arst_n,
	kvt_stream_if.sink   req,
	kvt_stream_if.source rsp
);
	import kvt_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN1 = 4'b0010,
		S_SCAN2 = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t             state_q;
	logic               start_q;
	kvt_req_t           req_q;
	logic [CNT_W-1:0]   count_q;
	logic signed [31:0] res_found_q;
	logic               res_hit_q;
	logic [1:0]         res_status_q;
	kvt_out_t           out_q;
	logic               out_valid_q;
	kvt_carry_t         carry [CAPACITY+1];
	logic [CAPACITY-1:0] act_vec;
	kvt_carry_t         tail;
	logic [31:0]        cnt_ext;
	logic               in_take;
	logic               out_free;

	// chain head and cells
	assign carry[0] = '{act: start_q, hit: 1'b0, taken: 1'b0, found: 32'sd0};

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		kvt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.req       (req_q),
			.carry_in  (carry[i]),
			.carry_out (carry[i+1])
		);
		assign act_vec[i] = carry[i+1].act;
	end

	assign tail = carry[CAPACITY];

	// handshakes
	assign req.ready = (state_q == S_IDLE);
	assign in_take   = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_q;
	assign cnt_ext   = 32'(count_q);

	// sequencer: search pass, optional fill pass, result hand-off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			start_q     <= 1'b0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new item, or a new key that needs a free slot, launches a token
			start_q <= in_take || (state_q == S_SCAN1 && tail.act &&
				req_q.kind == KIND_INSERT && !tail.hit);
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						state_q <= S_SCAN1;
					end
				end
				S_SCAN1: begin
					if (tail.act) begin
						if (req_q.kind == KIND_INSERT && !tail.hit) begin
							state_q <= S_SCAN2;
						end else begin
							if (req_q.kind == KIND_ERASE && tail.hit && count_q != '0) begin
								count_q <= count_q - CNT_W'(1);
							end
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN2: begin
					if (tail.act) begin
						if (tail.taken) begin
							count_q <= count_q + CNT_W'(1);
						end
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request latch and result fields
	always_ff @(posedge clk) begin
		if (in_take) begin
			req_q.kind      <= req.data.kind;
			req_q.req_key   <= req.data.req_key;
			req_q.req_value <= req.data.req_value;
			req_q.fill      <= 1'b0;
		end else if (state_q == S_SCAN1 && tail.act) begin
			req_q.fill <= 1'b1;
		end
		if (state_q == S_SCAN1 && tail.act) begin
			res_hit_q <= tail.hit && (req_q.kind != KIND_UNUSED);
			case (req_q.kind)
				KIND_LOOKUP: begin
					res_found_q  <= tail.hit ? tail.found : INT_MIN;
					res_status_q <= tail.hit ? ST_DONE : ST_MISS;
				end
				KIND_ERASE: begin
					res_found_q  <= 32'sd0;
					res_status_q <= tail.hit ? ST_DONE : ST_MISS;
				end
				default: begin
					res_found_q  <= 32'sd0;
					res_status_q <= ST_DONE;
				end
			endcase
		end
		if (state_q == S_SCAN2 && tail.act) begin
			res_status_q <= tail.taken ? ST_DONE : ST_FULL;
		end
		if (state_q == S_DONE && out_free) begin
			out_q.found_value <= res_found_q;
			out_q.hit         <= res_hit_q;
			out_q.status      <= res_status_q;
			out_q.entry_count <= cnt_ext[4:0];
		end
	end

`ifndef SYNTHESIS
	// the count never runs past the number of slots
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_ext <= CAPACITY)
		else $error("entry count above capacity");

	// at most one token travels the chain
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({start_q, act_vec}))
		else $error("more than one token on the chain");

	// an accepted item launches a search pass
	a_launch: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (state_q == S_SCAN1) && start_q)
		else $error("accepted item did not start a search");

	// a token only travels while a scan is running
	a_token_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(start_q || act_vec != '0) |-> (state_q == S_SCAN1 || state_q == S_SCAN2))
		else $error("token outside a scan");
`endif

endmodule

[hw/rtl/kvt_cell.sv]
// kvt_cell: one table slot (key, value, valid) and one stage of the token chain
// depends on kvt_pkg
module kvt_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  kvt_pkg::kvt_req_t   req,
	input  kvt_pkg::kvt_carry_t carry_in,
	output kvt_pkg::kvt_carry_t carry_out
);
	import kvt_pkg::*;

	logic               valid_q;
	logic signed [31:0] key_q;
	logic signed [31:0] val_q;
	logic               act_q;
	logic               hit_q;
	logic               taken_q;
	logic signed [31:0] found_q;
	logic               match;
	logic               place;

	// search pass: this slot holds the key; fill pass: first free slot takes it
	assign match = carry_in.act && !req.fill && !carry_in.hit && valid_q &&
		(key_q == req.req_key);
	assign place = carry_in.act && req.fill && !carry_in.taken && !valid_q;

	// slot occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (place) begin
			valid_q <= 1'b1;
		end else if (match && req.kind == KIND_ERASE) begin
			valid_q <= 1'b0;
		end
	end

	// slot contents
	always_ff @(posedge clk) begin
		if (place) begin
			key_q <= req.req_key;
			val_q <= req.req_value;
		end else if (match && req.kind == KIND_INSERT) begin
			val_q <= req.req_value;
		end
	end

	// token moves one cell per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
		end else begin
			act_q <= carry_in.act;
		end
	end

	// token payload
	always_ff @(posedge clk) begin
		hit_q   <= carry_in.hit | match;
		taken_q <= carry_in.taken | place;
		found_q <= match ? val_q : carry_in.found;
	end

	assign carry_out = '{act: act_q, hit: hit_q, taken: taken_q, found: found_q};

endmodule
